FILE: rtl/bsc_pkg.sv
// shared types, constants and microcode for the barometric compensation core
// no dependencies; compiled first

package bsc_pkg;

  localparam int unsigned VAL_W     = 64;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_NUM   = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_VARS  = 4;
  localparam int unsigned PC_W      = 6;
  localparam int unsigned OUT_W     = 19;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;

  // saturation limits
  localparam logic [VAL_W-1:0]        VLIM_MAG   = 64'h0004_0000_0000_0000;
  localparam logic signed [VAL_W-1:0] VLIM       = 64'sh0004_0000_0000_0000;
  localparam logic signed [VAL_W-1:0] INT32_MAXV = 64'sd2147483647;
  localparam logic signed [VAL_W-1:0] INT32_MINV = -64'sd2147483648;
  localparam logic [OUT_W-1:0]        OUT_HI_MAG = 19'd200000;
  localparam logic [OUT_W-1:0]        OUT_LO_MAG = 19'd100000;

  // program entry points
  localparam logic [PC_W-1:0] PC_TEMP = 6'd0;
  localparam logic [PC_W-1:0] PC_PRES = 6'd16;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_CLAMP, OP_CLAMP32, OP_MULI, OP_MULQ, OP_DIV, OP_HUND
  } op_e;

  typedef enum logic [5:0] {
    S_V0, S_V1, S_V2, S_V3, S_RAW, S_RAWONE, S_TOFF, S_AC1ONE,
    S_AC2, S_AC3, S_AC4, S_AC5, S_AC6, S_B1, S_B2, S_MC, S_MD, S_K25ONE,
    S_K45, S_K100, S_K160, S_K191, S_K195, S_K237, S_K458, S_K763, S_K812,
    S_K994, S_K1000, S_K72828, S_K149634, S_K10027008,
    S_K1E4, S_K1E6, S_K1E7, S_K1E9, S_K1E10, S_K1E15, S_K1E17
  } src_e;

  typedef struct packed {
    op_e        op;
    src_e       sa;
    src_e       sb;
    logic [1:0] dst;
  } uop_t;

  // plain integer constants of the formulas
  function automatic logic [VAL_W-1:0] k_const(input src_e s);
    logic [VAL_W-1:0] v;
    case (s)
      S_K45:       v = 64'd45;
      S_K100:      v = 64'd100;
      S_K160:      v = 64'd160;
      S_K191:      v = 64'd191;
      S_K195:      v = 64'd195;
      S_K237:      v = 64'd237;
      S_K458:      v = 64'd458;
      S_K763:      v = 64'd763;
      S_K812:      v = 64'd812;
      S_K994:      v = 64'd994;
      S_K1000:     v = 64'd1000;
      S_K72828:    v = 64'd72828;
      S_K149634:   v = 64'd149634;
      S_K10027008: v = 64'd10027008;
      S_K1E4:      v = 64'd10000;
      S_K1E6:      v = 64'd1000000;
      S_K1E7:      v = 64'd10000000;
      S_K1E9:      v = 64'd1000000000;
      S_K1E10:     v = 64'd10000000000;
      S_K1E15:     v = 64'd1000000000000000;
      S_K1E17:     v = 64'd100000000000000000;
      default:     v = '0;
    endcase
    return v;
  endfunction

  // microcode: temperature from PC_TEMP, pressure from PC_PRES, both end in OP_HUND
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // temperature
      6'd0:  u = '{OP_SUB,     S_RAW,    S_AC6,       2'd0};
      6'd1:  u = '{OP_MULI,    S_V0,     S_AC5,       2'd0};
      6'd2:  u = '{OP_MULI,    S_V0,     S_K191,      2'd0};
      6'd3:  u = '{OP_DIV,     S_V0,     S_K1E9,      2'd0};
      6'd4:  u = '{OP_MULI,    S_MC,     S_K812,      2'd1};
      6'd5:  u = '{OP_DIV,     S_V1,     S_K1E4,      2'd1};
      6'd6:  u = '{OP_DIV,     S_MD,     S_K160,      2'd2};
      6'd7:  u = '{OP_ADD,     S_V0,     S_V2,        2'd2};
      6'd8:  u = '{OP_CLAMP,   S_V2,     S_K100,      2'd2};
      6'd9:  u = '{OP_DIV,     S_V1,     S_V2,        2'd1};
      6'd10: u = '{OP_ADD,     S_V0,     S_V1,        2'd1};
      6'd11: u = '{OP_CLAMP,   S_V1,     S_K100,      2'd1};
      6'd12: u = '{OP_SUB,     S_V1,     S_K25ONE,    2'd2};
      6'd13: u = '{OP_CLAMP32, S_V2,     S_K100,      2'd2};
      6'd14: u = '{OP_HUND,    S_V1,     S_K100,      2'd0};
      // pressure
      6'd16: u = '{OP_MULQ,    S_TOFF,   S_TOFF,      2'd0};
      6'd17: u = '{OP_MULI,    S_B2,     S_K763,      2'd1};
      6'd18: u = '{OP_DIV,     S_V1,     S_K1E6,      2'd1};
      6'd19: u = '{OP_MULQ,    S_V1,     S_V0,        2'd1};
      6'd20: u = '{OP_MULI,    S_AC2,    S_K195,      2'd2};
      6'd21: u = '{OP_DIV,     S_V2,     S_K1E4,      2'd2};
      6'd22: u = '{OP_MULQ,    S_V2,     S_TOFF,      2'd2};
      6'd23: u = '{OP_ADD,     S_V1,     S_V2,        2'd1};
      6'd24: u = '{OP_ADD,     S_V1,     S_AC1ONE,    2'd1};
      6'd25: u = '{OP_CLAMP,   S_V1,     S_K100,      2'd1};
      6'd26: u = '{OP_MULI,    S_AC4,    S_K10027008, 2'd2};
      6'd27: u = '{OP_DIV,     S_V2,     S_K1E10,     2'd2};
      6'd28: u = '{OP_MULI,    S_AC4,    S_AC3,       2'd3};
      6'd29: u = '{OP_MULI,    S_V3,     S_K149634,   2'd3};
      6'd30: u = '{OP_DIV,     S_V3,     S_K1E15,     2'd3};
      6'd31: u = '{OP_MULQ,    S_V3,     S_TOFF,      2'd3};
      6'd32: u = '{OP_ADD,     S_V2,     S_V3,        2'd2};
      6'd33: u = '{OP_MULI,    S_AC4,    S_B1,        2'd3};
      6'd34: u = '{OP_MULI,    S_V3,     S_K72828,    2'd3};
      6'd35: u = '{OP_DIV,     S_V3,     S_K1E17,     2'd3};
      6'd36: u = '{OP_MULQ,    S_V3,     S_V0,        2'd3};
      6'd37: u = '{OP_ADD,     S_V2,     S_V3,        2'd2};
      6'd38: u = '{OP_CLAMP,   S_V2,     S_K100,      2'd2};
      6'd39: u = '{OP_SUB,     S_RAWONE, S_V1,        2'd3};
      6'd40: u = '{OP_CLAMP,   S_V3,     S_K100,      2'd3};
      6'd41: u = '{OP_DIV,     S_V3,     S_V2,        2'd3};
      6'd42: u = '{OP_MULQ,    S_V3,     S_V3,        2'd0};
      6'd43: u = '{OP_MULI,    S_V0,     S_K45,       2'd0};
      6'd44: u = '{OP_DIV,     S_V0,     S_K1E7,      2'd0};
      6'd45: u = '{OP_MULI,    S_V3,     S_K994,      2'd1};
      6'd46: u = '{OP_DIV,     S_V1,     S_K1000,     2'd1};
      6'd47: u = '{OP_ADD,     S_V0,     S_V1,        2'd0};
      6'd48: u = '{OP_DIV,     S_K237,   S_K100,      2'd1};
      6'd49: u = '{OP_ADD,     S_V0,     S_V1,        2'd0};
      6'd50: u = '{OP_DIV,     S_K458,   S_K100,      2'd1};
      6'd51: u = '{OP_ADD,     S_V0,     S_V1,        2'd0};
      6'd52: u = '{OP_CLAMP,   S_V0,     S_K100,      2'd0};
      6'd53: u = '{OP_HUND,    S_V0,     S_K100,      2'd0};
      default: u = '{OP_HUND,  S_V0,     S_K100,      2'd0};
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/bsc_if.sv
// valid/ready channel interfaces for raw readings and compensated results
// no dependencies

interface bsc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] raw_reading;
  modport source (output valid, operation, raw_reading, input ready);
  modport sink   (input valid, operation, raw_reading, output ready);
endinterface

interface bsc_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [18:0] value_hundredths;
  logic               status;
  modport source (output valid, kind, value_hundredths, status, input ready);
  modport sink   (input valid, kind, value_hundredths, status, output ready);
endinterface

FILE: rtl/bsc_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, with an addend
// depends on bsc_pkg

module bsc_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bsc_pkg::VAL_W-1:0]      mcand_i,
  input  logic [bsc_pkg::VAL_W-1:0]      mplier_i,
  input  logic [bsc_pkg::VAL_W-1:0]      addend_i,
  output logic                           done_o,
  output logic [2*bsc_pkg::VAL_W-1:0]    prod_o
);
  import bsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(VAL_W);

  logic [2*VAL_W-1:0] acc_q;
  logic [VAL_W-1:0]   mc_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [VAL_W:0]     psum;

  // partial sum on the upper half
  assign psum = {1'b0, acc_q[2*VAL_W-1:VAL_W]} + (acc_q[0] ? {1'b0, mc_q} : '0);

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(VAL_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // accumulator: addend rides in the upper half and lands in the sum
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {addend_i, mplier_i};
      mc_q  <= mcand_i;
    end else if (busy_q) begin
      acc_q <= {psum, acc_q[VAL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: rtl/bsc_div.sv
// restoring divider, one quotient bit per cycle, dividend scaled by 2^(FRAC_BITS+1)
// depends on bsc_pkg

module bsc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [bsc_pkg::VAL_W-1:0]         dividend_i,
  input  logic [bsc_pkg::VAL_W-1:0]         divisor_i,
  output logic                              done_o,
  output logic [bsc_pkg::VAL_W+FRAC_BITS:0] quot_o
);
  import bsc_pkg::*;

  localparam int unsigned DW    = VAL_W + FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd_q;
  logic [VAL_W-1:0] rem_q;
  logic [VAL_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;
  logic             ge;

  // trial subtract
  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and dividend/quotient shift line
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {dividend_i, (FRAC_BITS + 1)'(0)};
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      dvd_q <= {dvd_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

FILE: rtl/baro_sensor_compensation_core.sv
// top level of the barometric compensation core: sequencer, scratch values, ports
// depends on bsc_pkg, bsc_if, bsc_mul, bsc_div
//
//   channel   dir   handshake      word
//   in_i      in    valid/ready    operation, raw_reading
//   out_o     out   valid/ready    kind, value_hundredths, status
//   cfg       in    cfg_we_i       cfg_idx_i, cfg_wdata_i (no read-back)
//
// one reading at a time; a microcoded sequence runs on a 64-step serial multiplier
// and a (FRAC_BITS+65)-step restoring divider. ready is high only while idle; the
// result register lets the next reading in while a word still waits on out_o. async
// active-low reset clears control, the calibration words and the kept temperature
// offset.

module baro_sensor_compensation_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsc_pkg::CFG_W-1:0]      cfg_wdata_i,
  bsc_in_if.sink                         in_i,
  bsc_out_if.source                      out_o
);
  import bsc_pkg::*;

  localparam int unsigned DW  = VAL_W + FRAC_BITS + 1;
  localparam logic [VAL_W-1:0] RND = VAL_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_DIV, ST_OUT} state_e;

  state_e                   state_q;
  logic [PC_W-1:0]          pc_q;
  logic                     kind_q;
  logic [15:0]              raw_q;
  logic                     flag_q;
  logic signed [31:0]       toff_q;
  logic [CFG_W-1:0]         cal_q [CFG_NUM];
  uop_t                     uop_q;
  uop_t                     uop_rd;
  logic signed [VAL_W-1:0]  opa_q;
  logic signed [VAL_W-1:0]  opb_q;
  logic signed [VAL_W-1:0]  vars_q [NUM_VARS];
  logic signed [OUT_W-1:0]  res19_q;
  logic                     out_valid_q;
  logic                     out_kind_q;
  logic signed [OUT_W-1:0]  out_val_q;
  logic                     out_status_q;

  logic [VAL_W-1:0]         mag_a;
  logic [VAL_W-1:0]         mag_b;
  logic                     neg;
  logic                     opb_zero;
  logic                     op_is_mul;
  logic                     mul_start;
  logic                     mul_done;
  logic [2*VAL_W-1:0]       mul_prod;
  logic [2*VAL_W-1:0]       mq;
  logic                     mulq_sat;
  logic                     div_start;
  logic                     div_done;
  logic [DW-1:0]            div_quot;
  logic [DW-1:0]            dmag;
  logic                     div_sat;
  logic signed [VAL_W-1:0]  clamp_val;
  logic                     clamp_ovf;
  logic signed [31:0]       toff_val;
  logic                     toff_ovf;
  logic                     h_hi;
  logic                     h_lo;
  logic signed [OUT_W-1:0]  hund_val;
  logic                     wb_en;
  logic signed [VAL_W-1:0]  wb_val;
  logic                     flag_set;
  logic                     step_done;
  logic                     toff_we;
  logic                     hund_done;
  logic                     in_acc;

  // operand sources
  function automatic logic signed [VAL_W-1:0] src_val(input src_e s);
    logic signed [VAL_W-1:0] v;
    case (s)
      S_V0:     v = vars_q[0];
      S_V1:     v = vars_q[1];
      S_V2:     v = vars_q[2];
      S_V3:     v = vars_q[3];
      S_RAW:    v = VAL_W'(raw_q);
      S_RAWONE: v = VAL_W'(raw_q) << FRAC_BITS;
      S_TOFF:   v = VAL_W'(toff_q);
      S_AC1ONE: v = VAL_W'(signed'(cal_q[CFG_AC1_AC2][31:16])) <<< FRAC_BITS;
      S_AC2:    v = VAL_W'(signed'(cal_q[CFG_AC1_AC2][15:0]));
      S_AC3:    v = VAL_W'(signed'(cal_q[CFG_AC3_AC4][31:16]));
      S_AC4:    v = VAL_W'(cal_q[CFG_AC3_AC4][15:0]);
      S_AC5:    v = VAL_W'(cal_q[CFG_AC5_AC6][31:16]);
      S_AC6:    v = VAL_W'(cal_q[CFG_AC5_AC6][15:0]);
      S_B1:     v = VAL_W'(signed'(cal_q[CFG_B1_B2][31:16]));
      S_B2:     v = VAL_W'(signed'(cal_q[CFG_B1_B2][15:0]));
      S_MC:     v = VAL_W'(signed'(cal_q[CFG_MC_MD][31:16]));
      S_MD:     v = VAL_W'(signed'(cal_q[CFG_MC_MD][15:0]));
      S_K25ONE: v = VAL_W'(25) << FRAC_BITS;
      default:  v = signed'(k_const(s));
    endcase
    return v;
  endfunction

  function automatic logic signed [VAL_W-1:0] apply_sign(input logic [VAL_W-1:0] m,
                                                         input logic n);
    return n ? signed'(-m) : signed'(m);
  endfunction

  assign uop_rd = ucode(pc_q);
  assign in_acc = in_i.valid && (state_q == ST_IDLE);

  // magnitudes and sign of the operands
  assign mag_a    = opa_q[VAL_W-1] ? (~opa_q + VAL_W'(1)) : opa_q;
  assign mag_b    = opb_q[VAL_W-1] ? (~opb_q + VAL_W'(1)) : opb_q;
  assign neg      = opa_q[VAL_W-1] ^ opb_q[VAL_W-1];
  assign opb_zero = (opb_q == '0);

  assign op_is_mul = (uop_q.op == OP_MULI) || (uop_q.op == OP_MULQ) || (uop_q.op == OP_HUND);
  assign mul_start = (state_q == ST_EXEC) && op_is_mul;
  assign div_start = (state_q == ST_EXEC) && (uop_q.op == OP_DIV) && !opb_zero;

  bsc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mag_a),
    .mplier_i (mag_b),
    .addend_i ((uop_q.op == OP_MULI) ? '0 : RND),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  bsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_a),
    .divisor_i  (mag_b),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // rounded product and quotient, saturated
  assign mq       = mul_prod >> FRAC_BITS;
  assign mulq_sat = mq > (2*VAL_W)'(VLIM_MAG);
  assign dmag     = (div_quot + DW'(1)) >> 1;
  assign div_sat  = dmag > DW'(VLIM_MAG);

  // clamps
  assign clamp_ovf = (opa_q > VLIM) || (opa_q < -VLIM);
  assign clamp_val = (opa_q > VLIM) ? VLIM : ((opa_q < -VLIM) ? -VLIM : opa_q);
  assign toff_ovf  = (opa_q > INT32_MAXV) || (opa_q < INT32_MINV);
  assign toff_val  = (opa_q > INT32_MAXV) ? INT32_MAXV[31:0] :
                     ((opa_q < INT32_MINV) ? INT32_MINV[31:0] : opa_q[31:0]);

  // hundredths with output range saturation
  assign h_hi     = !neg && (mq > (2*VAL_W)'(OUT_HI_MAG));
  assign h_lo     = neg && (mq > (2*VAL_W)'(OUT_LO_MAG));
  assign hund_val = h_hi ? signed'(OUT_HI_MAG) :
                    (h_lo ? signed'(-OUT_LO_MAG) :
                    (neg ? signed'(-mq[OUT_W-1:0]) : signed'(mq[OUT_W-1:0])));

  // step results and write-back
  always_comb begin
    wb_en     = 1'b0;
    wb_val    = '0;
    flag_set  = 1'b0;
    step_done = 1'b0;
    toff_we   = 1'b0;
    hund_done = 1'b0;
    case (state_q)
      ST_EXEC: begin
        case (uop_q.op)
          OP_ADD: begin
            wb_en = 1'b1; wb_val = opa_q + opb_q; step_done = 1'b1;
          end
          OP_SUB: begin
            wb_en = 1'b1; wb_val = opa_q - opb_q; step_done = 1'b1;
          end
          OP_CLAMP: begin
            wb_en = 1'b1; wb_val = clamp_val; flag_set = clamp_ovf; step_done = 1'b1;
          end
          OP_CLAMP32: begin
            toff_we = 1'b1; flag_set = toff_ovf; step_done = 1'b1;
          end
          OP_DIV: begin
            // zero divisor saturates with the sign of the dividend
            if (opb_zero) begin
              wb_en     = 1'b1;
              wb_val    = (opa_q > 0) ? VLIM : ((opa_q < 0) ? -VLIM : '0);
              flag_set  = 1'b1;
              step_done = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        if (mul_done) begin
          case (uop_q.op)
            OP_MULI: begin
              wb_en = 1'b1; wb_val = apply_sign(mul_prod[VAL_W-1:0], neg); step_done = 1'b1;
            end
            OP_MULQ: begin
              wb_en     = 1'b1;
              wb_val    = apply_sign(mulq_sat ? VLIM_MAG : mq[VAL_W-1:0], neg);
              flag_set  = mulq_sat;
              step_done = 1'b1;
            end
            default: begin
              flag_set  = h_hi || h_lo;
              hund_done = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          wb_en     = 1'b1;
          wb_val    = apply_sign(div_sat ? VLIM_MAG : dmag[VAL_W-1:0], neg);
          flag_set  = div_sat;
          step_done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // calibration words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM; i++) cal_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(CFG_NUM))) begin
      cal_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // sequencer, kept offset and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pc_q         <= '0;
      kind_q       <= 1'b0;
      raw_q        <= '0;
      flag_q       <= 1'b0;
      toff_q       <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= 1'b0;
      out_val_q    <= '0;
      out_status_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) out_valid_q <= 1'b0;
      if (flag_set) flag_q <= 1'b1;
      if (toff_we) toff_q <= toff_val;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            kind_q  <= in_i.operation;
            raw_q   <= in_i.raw_reading;
            flag_q  <= 1'b0;
            pc_q    <= in_i.operation ? PC_PRES : PC_TEMP;
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: state_q <= ST_EXEC;
        ST_EXEC: begin
          if (step_done) begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= ST_FETCH;
          end else if (op_is_mul) begin
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_MUL: begin
          if (hund_done) begin
            state_q <= ST_OUT;
          end else if (step_done) begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= ST_FETCH;
          end
        end
        ST_DIV: begin
          if (step_done) begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= ST_FETCH;
          end
        end
        ST_OUT: begin
          // hand the word over once the result register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= kind_q;
            out_val_q    <= res19_q;
            out_status_q <= flag_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // operand fetch, scratch values, final value
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH) begin
      uop_q <= uop_rd;
      opa_q <= src_val(uop_rd.sa);
      opb_q <= src_val(uop_rd.sb);
    end
    if (wb_en) vars_q[uop_q.dst] <= wb_val;
    if (hund_done) res19_q <= hund_val;
  end

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = out_kind_q;
  assign out_o.value_hundredths = out_val_q;
  assign out_o.status           = out_status_q;

endmodule

FILE: sim/baro_sensor_compensation_core_tb.sv
// testbench for the barometric compensation core: directed and random readings
// checked word by word against a fixed-point predictor; uses bsc_pkg, bsc_if and the rtl

module baro_sensor_compensation_core_tb;
  import bsc_pkg::*;

  localparam int          FRAC      = 16;
  localparam longint      ONE       = longint'(1) << FRAC;
  localparam longint      SAT_LIM   = longint'(1) << 50;
  localparam int unsigned CYCLE_CAP = 4000000;

  // idling modes
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct packed {
    logic              kind;
    logic signed [18:0] value;
    logic              status;
  } comp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  bsc_in_if  in_ch ();
  bsc_out_if out_ch ();

  baro_sensor_compensation_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // clock, period 12
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] cal_regs [CFG_NUM];
  longint      kept_offset;
  bit          sat_seen;
  comp_word_t  pending_words [$];

  idle_e  idle_mode = IDLE_NONE;
  int     hold_left = 0;
  int     mismatch_count = 0;
  int     word_count = 0;
  int     temp_count = 0;
  int     pres_count = 0;
  int unsigned cycle_count = 0;

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint signed_cap(logic [63:0] mag, bit neg);
    if (mag > 64'(SAT_LIM)) begin
      sat_seen = 1'b1;
      mag = 64'(SAT_LIM);
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_val(longint v);
    if (v > SAT_LIM) begin
      sat_seen = 1'b1;
      return SAT_LIM;
    end
    if (v < -SAT_LIM) begin
      sat_seen = 1'b1;
      return -SAT_LIM;
    end
    return v;
  endfunction

  // rounded fixed-point product
  function automatic longint fix_mul(longint x, longint y);
    logic [127:0] prod;
    logic [63:0]  lo;
    prod = {64'd0, magnitude(x)} * {64'd0, magnitude(y)};
    prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
    if (prod[127:64] != 0) begin
      sat_seen = 1'b1;
      lo = 64'(SAT_LIM);
    end else begin
      lo = prod[63:0];
    end
    return signed_cap(lo, (x < 0) != (y < 0));
  endfunction

  // rounded fixed-point quotient, zero divisor saturates
  function automatic longint fix_div(longint n, longint d);
    logic [63:0] un, ud, q, r;
    bit neg;
    neg = (n < 0) != (d < 0);
    if (d == 0) begin
      sat_seen = 1'b1;
      return (n > 0) ? SAT_LIM : ((n < 0) ? -SAT_LIM : 0);
    end
    un = magnitude(n);
    ud = magnitude(d);
    q = un / ud;
    r = un % ud;
    if (q > (64'(SAT_LIM) >> FRAC)) begin
      sat_seen = 1'b1;
      return signed_cap(64'(SAT_LIM), neg);
    end
    for (int i = 0; i <= FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 64'd1;
      end
    end
    return signed_cap((q + 64'd1) >> 1, neg);
  endfunction

  function automatic logic signed [18:0] to_hundredths(longint v);
    logic [63:0] m;
    longint h;
    m = (magnitude(v) * 64'd100 + (64'd1 << (FRAC - 1))) >> FRAC;
    h = (v < 0) ? -longint'(m) : longint'(m);
    if (h > 200000) begin
      sat_seen = 1'b1;
      h = 200000;
    end
    if (h < -100000) begin
      sat_seen = 1'b1;
      h = -100000;
    end
    return h[18:0];
  endfunction

  function automatic longint half_s(logic [15:0] h);
    return longint'($signed(h));
  endfunction

  function automatic longint half_u(logic [15:0] h);
    return longint'({48'd0, h});
  endfunction

  // compensated word for one reading; updates the kept offset
  function automatic comp_word_t compensate(logic op, logic [15:0] raw_in);
    comp_word_t w;
    longint raw, a, mcq, mdq, t, s, s2, x0, x1, x2, y0, y1, y2, pa, pb, c, c2, p;
    raw = half_u(raw_in);
    sat_seen = 1'b0;
    if (op == 1'b0) begin
      a   = fix_div(half_u(cal_regs[CFG_AC5_AC6][31:16]) *
                    (raw - half_u(cal_regs[CFG_AC5_AC6][15:0])) * 191, 1000000000);
      mcq = fix_div(half_s(cal_regs[CFG_MC_MD][31:16]) * 812, 10000);
      mdq = fix_div(half_s(cal_regs[CFG_MC_MD][15:0]), 160);
      t   = clamp_val(a + fix_div(mcq, clamp_val(a + mdq)));
      s   = t - 25 * ONE;
      if (s > 64'sd2147483647) begin
        sat_seen = 1'b1;
        s = 64'sd2147483647;
      end
      if (s < -64'sd2147483648) begin
        sat_seen = 1'b1;
        s = -64'sd2147483648;
      end
      kept_offset = s;
      w.value = to_hundredths(t);
    end else begin
      s  = kept_offset;
      s2 = fix_mul(s, s);
      x0 = half_s(cal_regs[CFG_AC1_AC2][31:16]) * ONE;
      x1 = fix_div(half_s(cal_regs[CFG_AC1_AC2][15:0]) * 195, 10000);
      x2 = fix_div(half_s(cal_regs[CFG_B1_B2][15:0]) * 763, 1000000);
      y0 = fix_div(half_u(cal_regs[CFG_AC3_AC4][15:0]) * 10027008, 64'sd10000000000);
      y1 = fix_div(half_u(cal_regs[CFG_AC3_AC4][15:0]) *
                   half_s(cal_regs[CFG_AC3_AC4][31:16]) * 149634, 64'sd1000000000000000);
      y2 = fix_div(half_u(cal_regs[CFG_AC3_AC4][15:0]) *
                   half_s(cal_regs[CFG_B1_B2][31:16]) * 72828, 64'sd100000000000000000);
      pa = clamp_val(fix_mul(x2, s2) + fix_mul(x1, s) + x0);
      pb = clamp_val(fix_mul(y2, s2) + fix_mul(y1, s) + y0);
      c  = fix_div(clamp_val(raw * ONE - pa), pb);
      c2 = fix_mul(c, c);
      p  = fix_div(c2 * 45, 10000000) + fix_div(c * 994, 1000)
         + fix_div(237, 100) + fix_div(458, 100);
      p  = clamp_val(p);
      w.value = to_hundredths(p);
    end
    w.kind = op;
    w.status = sat_seen;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on word %0d: %s got %0d want %0d", word_count, what, got, want);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, kind", out_ch.kind, -1);
      end else begin
        comp_word_t w;
        w = pending_words.pop_front();
        if (out_ch.kind !== w.kind) report_mismatch("kind", out_ch.kind, w.kind);
        if (out_ch.value_hundredths !== w.value)
          report_mismatch("value", out_ch.value_hundredths, w.value);
        if (out_ch.status !== w.status) report_mismatch("status", out_ch.status, w.status);
      end
      word_count++;
    end
  end

  // receiver ready, with a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_mode == IDLE_RECV) begin
      out_ch.ready <= ($urandom_range(99) >= 76);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ch.ready <= ($urandom_range(99) >= 37);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // offer one reading and wait for it to be taken
  task automatic send_reading(logic op, logic [15:0] raw);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 76 : ((idle_mode == IDLE_BOTH) ? 37 : 0);
    @(negedge clk_i);
    while (pct > 0 && $urandom_range(99) < pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.raw_reading = raw;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_words.push_back(compensate(op, raw));
    if (op) pres_count++;
    else temp_count++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    if (idx < CFG_NUM) cal_regs[idx] = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_cal(logic [31:0] r0, r1, r2, r3, r4);
    write_cal(CFG_AC1_AC2, r0);
    write_cal(CFG_AC3_AC4, r1);
    write_cal(CFG_AC5_AC6, r2);
    write_cal(CFG_B1_B2, r3);
    write_cal(CFG_MC_MD, r4);
  endtask

  // typical sensor calibration
  task automatic load_typical_cal();
    load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
             {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868});
  endtask

  // pressure right after reset sees a zero offset
  task automatic test_pressure_first();
    send_reading(1'b1, 16'd23843);
    send_reading(1'b1, 16'd0);
    wait_drained();
  endtask

  task automatic test_typical_readings();
    load_typical_cal();
    send_reading(1'b0, 16'd27898);
    send_reading(1'b1, 16'd23843);
    send_reading(1'b1, 16'd0);
    send_reading(1'b1, 16'hFFFF);
    send_reading(1'b0, 16'd0);
    send_reading(1'b1, 16'd23843);
    send_reading(1'b0, 16'hFFFF);
    send_reading(1'b1, 16'd40000);
    wait_drained();
  endtask

  // all-zero calibration divides by zero
  task automatic test_zero_divisor();
    load_cal('0, '0, '0, '0, '0);
    send_reading(1'b0, 16'd1234);
    send_reading(1'b1, 16'd1234);
    send_reading(1'b1, 16'd0);
    wait_drained();
  endtask

  // extreme words drive saturation and the offset clamp
  task automatic test_extreme_cal();
    load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_reading(1'b0, 16'hFFFF);
    send_reading(1'b1, 16'hFFFF);
    send_reading(1'b0, 16'd0);
    send_reading(1'b1, 16'd0);
    wait_drained();
    load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_7FFF, 32'h8000_0001);
    send_reading(1'b0, 16'hFFFF);
    send_reading(1'b1, 16'h8000);
    send_reading(1'b0, 16'd0);
    send_reading(1'b1, 16'h7FFF);
    wait_drained();
  endtask

  // indexes past the last register leave the calibration alone
  task automatic test_ignored_index();
    load_typical_cal();
    for (int i = CFG_NUM; i < (1 << CFG_IDX_W); i++) write_cal(i[CFG_IDX_W-1:0], 32'hDEAD_BEEF);
    send_reading(1'b0, 16'd27898);
    send_reading(1'b1, 16'd23843);
    wait_drained();
  endtask

  // receiver holds off while readings keep coming, then sender pauses until drained
  task automatic test_backpressure();
    hold_left = 6000;
    for (int i = 0; i < 6; i++) send_reading(i[0], 16'($urandom_range(20000, 35000)));
    wait_drained();
  endtask

  function automatic logic [15:0] jitter(logic [15:0] base, int spread);
    return base + 16'($urandom_range(2 * spread) - spread);
  endfunction

  // random readings under one idling mode; mostly a temperature followed by pressures
  task automatic test_random(idle_e mode, int count, bit wild_cal);
    int sent;
    if (wild_cal)
      load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
    else
      load_cal({jitter(16'd408, 300), jitter(-16'sd72, 200)},
               {jitter(-16'sd14383, 2000), jitter(16'd32741, 3000)},
               {jitter(16'd32757, 3000), jitter(16'd23153, 3000)},
               {jitter(16'd6190, 1000), jitter(16'd4, 50)},
               {jitter(-16'sd8711, 1000), jitter(16'd2868, 500)});
    idle_mode = mode;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        send_reading(1'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_reading(1'b0, ($urandom_range(3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(20000, 36000)));
        sent++;
        for (int k = $urandom_range(1, 4); k > 0 && sent < count; k--) begin
          send_reading(1'b1, ($urandom_range(3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(15000, 45000)));
          sent++;
        end
      end
    end
    wait_drained();
    idle_mode = IDLE_NONE;
  endtask

  initial begin
    for (int i = 0; i < CFG_NUM; i++) cal_regs[i] = '0;
    kept_offset = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.raw_reading = '0;
    out_ch.ready = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_pressure_first();
    test_typical_readings();
    test_zero_divisor();
    test_extreme_cal();
    test_ignored_index();
    test_backpressure();
    test_random(IDLE_NONE, 100, 1'b0);
    test_random(IDLE_SEND, 100, 1'b0);
    test_random(IDLE_RECV, 100, 1'b1);
    test_random(IDLE_BOTH, 100, 1'b0);

    $display("covered %0d temperature and %0d pressure readings, %0d words checked",
             temp_count, pres_count, word_count);
    $display("calibration sets: typical, zero, extreme, random; all idling modes and hold-off");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
